// ===== rtl/dva_pkg.sv =====
package dva_pkg;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_PLACE = 2'd2;

    // result action codes
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_FREED  = 3'd4;

    // configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_MASTER = 1'b1;

    // distances in 16.16 units, held at 34 bits
    localparam int          DIST_W     = 34;
    localparam logic [33:0] CLIP_DIST  = 34'd78643200;  // 1200 units
    localparam logic [33:0] CLOSE_DIST = 34'd10485760;  // 160 units
    localparam logic [10:0] FULL_LEVEL = 11'd1040;
    localparam logic [6:0]  MASTER_FULL = 7'd120;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        origin_id;
        logic [7:0]         sfx_id;
        logic               sound_present;
        logic signed [31:0] listener_x;
        logic signed [31:0] listener_y;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic [2:0]         voice_index;
        logic [7:0]         playing_mask;
    } dva_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  voice;
        logic [16:0] level;
        logic [7:0]  stop_mask;
    } dva_out_t;

    // distance unit result back to the sequencer
    typedef struct packed {
        logic        done;
        logic [10:0] level;
    } dva_dist_res_t;

endpackage

// ===== rtl/distance_voice_allocator.sv =====
// Channel  | Ports                     | Payload   | Direction
// -------- | ------------------------- | --------- | ---------
// command  | s_valid, s_ready, s_data  | dva_in_t  | in
// result   | m_valid, m_ready, m_data  | dva_out_t | out
// config   | cfg_we, cfg_addr, cfg_wdata | 0 enable, 1 master | in
//
// One transaction at a time: s_ready is high only while the sequencer idles.
// Start and re-place run the distance unit (one shared 34-bit adder reused for
// dx, dy, sum, difference and excess); start and stop then walk the voice file
// one voice per cycle. The result sits in an output register, so a stalled
// m_ready only blocks once the next result is ready to leave.
// Reset (aresetn low, synchronous) clears voice sources and levels, disables
// sound and sets master volume to full scale.
module distance_voice_allocator
    import dva_pkg::*;
#(
    parameter int VOICE_COUNT = 8,
    parameter int SOUND_COUNT = 128
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dva_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output dva_out_t m_data,
    input  logic     cfg_we,
    input  logic     cfg_addr,
    input  logic [6:0] cfg_wdata
);

    localparam int VI = $clog2(VOICE_COUNT);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIST   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;   // start: idle / quietest search
    localparam logic [2:0] ST_STOP   = 3'd3;   // stop: origin match walk
    localparam logic [2:0] ST_PLACE  = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    // voice file
    logic [15:0] src_reg [VOICE_COUNT];
    logic [10:0] vlvl_reg [VOICE_COUNT];
    logic        we_src, we_lvl;
    logic [VI-1:0] wr_idx;
    logic [15:0] wr_src;
    logic [10:0] wr_lvl;

    // config
    logic       en_reg;
    logic [6:0] mvol_reg;

    // sequencer
    logic [2:0]    state_reg, state_next;
    dva_in_t       in_reg;
    logic [VI-1:0] cnt_reg, cnt_next;
    logic [VI-1:0] pick_reg, pick_next;
    logic          found_reg, found_next;
    logic          idle_reg, idle_next;
    logic [10:0]   worst_reg, worst_next;
    logic [10:0]   lvl_reg, lvl_next;
    logic [2:0]    act_reg, act_next;
    logic [7:0]    smask_reg, smask_next;
    logic          scale_reg, scale_next;

    logic          m_valid_reg, m_valid_next;
    dva_out_t      m_data_reg, m_data_next;

    dva_dist_res_t dist_res;
    logic          dist_start;
    logic          accept;
    logic [4:0]    cnt_ext, pick_ext;
    logic          cur_play;
    logic          last;
    logic [10:0]   start_lvl;
    logic          start_ok;
    logic [6:0]    mclamp;
    logic [17:0]   prod;

    dva_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dist_start),
        .item    (in_reg),
        .res     (dist_res)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign cnt_ext  = 5'(cnt_reg);
    assign pick_ext = 5'(pick_reg);
    // voices 8 and up have no mask bit and read as idle
    assign cur_play = !cnt_ext[4] && !cnt_ext[3] && in_reg.playing_mask[cnt_ext[2:0]];
    assign last     = (cnt_reg == VI'(VOICE_COUNT - 1));

    // no-source starts play at full level
    assign start_lvl = (in_reg.origin_id == 16'd0) ? FULL_LEVEL : dist_res.level;
    assign start_ok  = (in_reg.sfx_id != 8'd0) && (32'(in_reg.sfx_id) < SOUND_COUNT)
                       && (start_lvl != 11'd0) && in_reg.sound_present;

    assign mclamp = (mvol_reg > MASTER_FULL) ? MASTER_FULL : mvol_reg;
    assign prod   = 18'(lvl_reg) * 18'(mclamp);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pick_next    = pick_reg;
        found_next   = found_reg;
        idle_next    = idle_reg;
        worst_next   = worst_reg;
        lvl_next     = lvl_reg;
        act_next     = act_reg;
        smask_next   = smask_reg;
        scale_next   = scale_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        dist_start   = 1'b0;
        we_src       = 1'b0;
        we_lvl       = 1'b0;
        wr_idx       = cnt_reg;
        wr_src       = 16'd0;
        wr_lvl       = lvl_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    pick_next  = '0;
                    found_next = 1'b0;
                    idle_next  = 1'b0;
                    act_next   = ACT_NONE;
                    smask_next = 8'd0;
                    scale_next = 1'b0;
                    if (!en_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        case (s_data.cmd)
                            CMD_START: begin
                                dist_start = 1'b1;
                                state_next = ST_DIST;
                            end
                            CMD_STOP: begin
                                state_next = ST_STOP;
                            end
                            CMD_PLACE: begin
                                if (32'(s_data.voice_index) < VOICE_COUNT) begin
                                    cnt_next   = VI'(s_data.voice_index);
                                    dist_start = 1'b1;
                                    state_next = ST_DIST;
                                end else begin
                                    state_next = ST_FINISH;
                                end
                            end
                            default: begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end
                end
            end
            ST_DIST: begin
                if (dist_res.done) begin
                    if (in_reg.cmd == CMD_START) begin
                        lvl_next   = start_lvl;
                        worst_next = start_lvl;
                        state_next = start_ok ? ST_SCAN : ST_FINISH;
                    end else begin
                        lvl_next   = dist_res.level;
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_SCAN: begin
                if (!cur_play) begin
                    idle_next  = 1'b1;
                    pick_next  = cnt_reg;
                    state_next = ST_COMMIT;
                end else begin
                    if (vlvl_reg[cnt_reg] < worst_reg) begin
                        worst_next = vlvl_reg[cnt_reg];
                        pick_next  = cnt_reg;
                        found_next = 1'b1;
                    end
                    if (last) begin
                        state_next = ST_COMMIT;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_COMMIT: begin
                if (idle_reg || found_reg) begin
                    we_src     = 1'b1;
                    we_lvl     = 1'b1;
                    wr_idx     = pick_reg;
                    wr_src     = in_reg.origin_id;
                    act_next   = ACT_START;
                    scale_next = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_STOP: begin
                if (src_reg[cnt_reg] == in_reg.origin_id) begin
                    we_src = 1'b1;
                    if (!cnt_ext[4] && !cnt_ext[3]) begin
                        smask_next = smask_reg | (8'd1 << cnt_ext[2:0]);
                    end
                    if (!found_reg) begin
                        found_next = 1'b1;
                        pick_next  = cnt_reg;
                        act_next   = ACT_STOP;
                    end
                end
                if (last) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PLACE: begin
                pick_next = cnt_reg;
                if (src_reg[cnt_reg] != 16'd0) begin
                    if (!cur_play) begin
                        we_src   = 1'b1;
                        act_next = ACT_FREED;
                    end else if (lvl_reg == 11'd0) begin
                        // out of range: voice is stopped and freed
                        we_src   = 1'b1;
                        act_next = ACT_STOP;
                    end else begin
                        we_lvl     = 1'b1;
                        act_next   = ACT_UPDATE;
                        scale_next = 1'b1;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.action    = act_reg;
                    m_data_next.voice     = (act_reg == ACT_NONE) ? 3'd0 : pick_ext[2:0];
                    m_data_next.level     = scale_reg ? prod[16:0] : 17'd0;
                    m_data_next.stop_mask = smask_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            en_reg      <= 1'b0;
            mvol_reg    <= MASTER_FULL;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                src_reg[i]  <= 16'd0;
                vlvl_reg[i] <= 11'd0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ENABLE: en_reg   <= cfg_wdata[0];
                    CFG_MASTER: mvol_reg <= cfg_wdata;
                    default:    en_reg   <= en_reg;
                endcase
            end
            if (we_src) begin
                src_reg[wr_idx] <= wr_src;
            end
            if (we_lvl) begin
                vlvl_reg[wr_idx] <= wr_lvl;
            end
        end
        if (accept) begin
            in_reg <= s_data;
        end
        cnt_reg    <= cnt_next;
        pick_reg   <= pick_next;
        found_reg  <= found_next;
        idle_reg   <= idle_next;
        worst_reg  <= worst_next;
        lvl_reg    <= lvl_next;
        act_reg    <= act_next;
        smask_reg  <= smask_next;
        scale_reg  <= scale_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/dva_dist.sv =====
module dva_dist
    import dva_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  dva_in_t       item,
    output dva_dist_res_t res
);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_DX   = 3'd1;
    localparam logic [2:0] D_DY   = 3'd2;
    localparam logic [2:0] D_SUM  = 3'd3;
    localparam logic [2:0] D_DIF  = 3'd4;
    localparam logic [2:0] D_LVL  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [DIST_W-1:0] adx_reg, adx_next;
    logic [DIST_W-1:0] ady_reg, ady_next;
    logic [DIST_W-1:0] acc_reg, acc_next;     // sum, then distance
    logic [DIST_W-1:0] half_reg, half_next;
    logic [10:0]       level_reg, level_next;
    logic              done_reg, done_next;

    // shared add/subtract unit
    logic [DIST_W-1:0] alu_a, alu_b, alu_y;
    logic              alu_sub;
    logic [DIST_W-1:0] ext_l, ext_s;
    logic              swap;

    always_comb begin
        ext_l = '0;
        ext_s = '0;
        swap  = 1'b0;
        alu_a = '0;
        alu_b = '0;
        alu_sub = 1'b0;
        case (state_reg)
            D_DX: begin
                ext_l = {{2{item.listener_x[31]}}, item.listener_x};
                ext_s = {{2{item.source_x[31]}}, item.source_x};
                swap  = item.listener_x < item.source_x;
                alu_a = swap ? ext_s : ext_l;
                alu_b = swap ? ext_l : ext_s;
                alu_sub = 1'b1;
            end
            D_DY: begin
                ext_l = {{2{item.listener_y[31]}}, item.listener_y};
                ext_s = {{2{item.source_y[31]}}, item.source_y};
                swap  = item.listener_y < item.source_y;
                alu_a = swap ? ext_s : ext_l;
                alu_b = swap ? ext_l : ext_s;
                alu_sub = 1'b1;
            end
            D_SUM: begin
                alu_a = adx_reg;
                alu_b = ady_reg;
            end
            D_DIF: begin
                alu_a = acc_reg;
                alu_b = half_reg;
                alu_sub = 1'b1;
            end
            D_LVL: begin
                alu_a = acc_reg;
                alu_b = CLOSE_DIST;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    always_comb begin
        state_next = state_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        acc_next   = acc_reg;
        half_next  = half_reg;
        level_next = level_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    state_next = D_DX;
                end
            end
            D_DX: begin
                adx_next   = alu_y;
                state_next = D_DY;
            end
            D_DY: begin
                ady_next   = alu_y;
                state_next = D_SUM;
            end
            D_SUM: begin
                acc_next   = alu_y;
                half_next  = ((adx_reg < ady_reg) ? adx_reg : ady_reg) >> 1;
                state_next = D_DIF;
            end
            D_DIF: begin
                acc_next   = alu_y;
                state_next = D_LVL;
            end
            D_LVL: begin
                if (acc_reg > CLIP_DIST) begin
                    level_next = '0;
                end else if (acc_reg <= CLOSE_DIST) begin
                    level_next = FULL_LEVEL;
                end else if (alu_y[33:16] >= 18'(FULL_LEVEL)) begin
                    level_next = '0;
                end else begin
                    level_next = FULL_LEVEL - alu_y[26:16];
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        acc_reg   <= acc_next;
        half_reg  <= half_next;
        level_reg <= level_next;
    end

    assign res.done  = done_reg;
    assign res.level = level_reg;

endmodule

// ===== rtl/dva_checker.sv =====
module dva_checker
    import dva_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input dva_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second command while busy");

    // empty results carry no voice, level or mask
    a_none_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == ACT_NONE |->
            m_data.voice == 3'd0 && m_data.level == 17'd0 && m_data.stop_mask == 8'd0)
        else $error("empty result with payload");

    // level only on start or update
    a_level_only_play: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != ACT_START && m_data.action != ACT_UPDATE |->
            m_data.level == 17'd0)
        else $error("level on non-play result");

    // a stop mask implies a stop
    a_mask_is_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stop_mask != 8'd0 |-> m_data.action == ACT_STOP)
        else $error("stop mask without stop action");

endmodule

bind distance_voice_allocator dva_checker u_dva_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
